/* src/tlbl_pkg.sv */
// tlbl_pkg: shared types and constants of the process-tagged lru translation buffer
// used by tlbl_cell, tlb_lru_process_tagged and tlbl_checker; no dependencies
package tlbl_pkg;

   localparam int FRAME_BITS = 10;
   localparam int PROC_BITS  = 16;
   localparam int PAGE_BITS  = 16;
   localparam int REMOVED_W  = 5;
   localparam int ENTRIES_W  = 5;

   // request codes
   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_FILL   = 2'd1;
   localparam logic [1:0] REQ_INVAL  = 2'd2;
   localparam logic [1:0] REQ_FLUSH  = 2'd3;

   // register indexes (paddr bit 2)
   localparam logic CSR_ENTRIES = 1'b0;
   localparam logic CSR_ENABLED = 1'b1;

   localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd16;

   // cell commands
   typedef logic [2:0] cell_op_type;
   localparam cell_op_type CELL_HOLD    = 3'd0;
   localparam cell_op_type CELL_SHIFT   = 3'd1;
   localparam cell_op_type CELL_DROP    = 3'd2;
   localparam cell_op_type CELL_CLEAR   = 3'd3;
   localparam cell_op_type CELL_COMPACT = 3'd4;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [PROC_BITS-1:0]  proc_id;
      logic [PAGE_BITS-1:0]  page_num;
      logic [FRAME_BITS-1:0] frame_num;
   } tlbl_req_type;

   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame_out;
      logic                  evicted;
      logic [REMOVED_W-1:0]  removed_count;
   } tlbl_rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [PROC_BITS-1:0]  proc_id;
      logic [PAGE_BITS-1:0]  page_num;
      logic [FRAME_BITS-1:0] frame;
   } tlbl_entry_type;

   typedef struct packed {
      cell_op_type          op;
      logic [PROC_BITS-1:0] proc_id;
      logic [PAGE_BITS-1:0] page_num;
   } tlbl_cmd_type;

endpackage

/* src/tlbl_cell.sv */
// tlbl_cell: one slot of the recency-ordered chain; position in the chain is the rank
// depends on tlbl_pkg
module tlbl_cell
   import tlbl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  tlbl_cmd_type   cmd,
   input  logic           shift_en,
   input  tlbl_entry_type prev_entry,
   input  tlbl_entry_type next_entry,
   output tlbl_entry_type entry_out,
   output logic           match,
   output logic           proc_match
);

   logic                  valid_ff, valid_in;
   logic [PROC_BITS-1:0]  proc_ff, proc_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;

   assign proc_match = valid_ff && (proc_ff == cmd.proc_id);
   assign match      = proc_match && (page_ff == cmd.page_num);

   assign entry_out.valid    = valid_ff;
   assign entry_out.proc_id  = proc_ff;
   assign entry_out.page_num = page_ff;
   assign entry_out.frame    = frame_ff;

   always_comb begin
      valid_in = valid_ff;
      proc_in  = proc_ff;
      page_in  = page_ff;
      frame_in = frame_ff;
      case (cmd.op)
         CELL_SHIFT: begin
            if (shift_en) begin
               valid_in = prev_entry.valid;
               proc_in  = prev_entry.proc_id;
               page_in  = prev_entry.page_num;
               frame_in = prev_entry.frame;
            end
         end
         CELL_DROP: begin
            if (proc_match) begin
               valid_in = 1'b0;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         CELL_COMPACT: begin
            // holes bubble toward the tail one cell per cycle
            if (!valid_ff) begin
               valid_in = next_entry.valid;
               proc_in  = next_entry.proc_id;
               page_in  = next_entry.page_num;
               frame_in = next_entry.frame;
            end else if (!prev_entry.valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff  <= proc_in;
      page_ff  <= page_in;
      frame_ff <= frame_in;
   end

endmodule

/* src/tlb_lru_process_tagged.sv */
// tlb_lru_process_tagged: fully associative translation buffer, lru order kept by a cell chain
// depends on tlbl_pkg and tlbl_cell
//
// Requests enter on req_valid/req_data and are accepted when req_stall is low; each beat
// gives exactly one rsp beat on rsp_valid/rsp_data, taken when rsp_stall is low.
// One request is worked at a time: req_stall is low only when the block is idle.
// Entries sit in a chain of TLB_DEPTH cells ordered by recency, cell 0 most recent.
// Lookup, fill and flush are accepted in the idle state and worked in the exec state once
// the output register is free: the parallel tag compare and the one-step shift of the chain
// toward the tail, or the clear of the chain for a flush. Invalidate drops every cell of the
// request's process, then the chain compacts one cell per cycle in the sweep state while the
// removed entries are counted, then the result is written once the output register is free.
// A finished result waits in the output register while rsp_stall is high; a new request
// is still accepted, and it completes once that register is free.
// Reset empties the buffer and sets tlb_entries to 16 and tlb_enabled to 1.
// Registers sit on an APB-style port: tlb_entries at 0x0, tlb_enabled at 0x4.
module tlb_lru_process_tagged
   import tlbl_pkg::*;
#(
   parameter int TLB_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tlbl_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tlbl_rsp_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int CNT_W = $clog2(TLB_DEPTH + 1);
   localparam int SWP_W = $clog2(TLB_DEPTH);
   localparam int LIM_W = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]           state_ff, state_in;
   tlbl_req_type         req_ff, req_in;
   tlbl_rsp_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SWP_W-1:0]     sweep_ff, sweep_in;
   logic [TLB_DEPTH-1:0] rmv_ff, rmv_in;
   logic [ENTRIES_W-1:0] entries_ff, entries_in;
   logic                 enabled_ff, enabled_in;

   tlbl_cmd_type         cmd;
   cell_op_type          cmd_op;
   tlbl_entry_type       front;
   tlbl_entry_type       cell_q [TLB_DEPTH];
   logic [TLB_DEPTH-1:0] valid_vec, match_vec, proc_vec, stop_vec, shift_vec, last_vec;
   logic [FRAME_BITS-1:0] hit_frame;
   logic                 any_match, insert_ok, out_free, accept, cfg_write;
   logic [LIM_W-1:0]     ent_ext, used_ext, limit;
   logic [CNT_W+REMOVED_W-1:0] used_wide, cnt_wide;
   logic [LIM_W+ENTRIES_W-1:0] ent_wide;
   logic [LIM_W+CNT_W-1:0]     used_lim_wide;

   // ---------------- cell chain ----------------
   assign front.valid    = 1'b1;
   assign front.proc_id  = req_ff.proc_id;
   assign front.page_num = req_ff.page_num;
   assign front.frame    = any_match ? hit_frame : req_ff.frame_num;

   assign cmd.op       = cmd_op;
   assign cmd.proc_id  = req_ff.proc_id;
   assign cmd.page_num = req_ff.page_num;

   for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
      tlbl_entry_type prev_e, next_e;
      if (g == 0) begin : g_head
         assign prev_e = front;
      end else begin : g_mid
         assign prev_e = cell_q[g-1];
      end
      if (g == TLB_DEPTH - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_body
         assign next_e = cell_q[g+1];
      end

      tlbl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .shift_en   (shift_vec[g]),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry_out  (cell_q[g]),
         .match      (match_vec[g]),
         .proc_match (proc_vec[g])
      );
      assign valid_vec[g] = cell_q[g].valid;
   end

   assign any_match = |match_vec;
   assign last_vec  = valid_vec & ~({1'b0, valid_vec[TLB_DEPTH-1:1]});

   always_comb begin
      hit_frame = '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
         hit_frame = hit_frame | (cell_q[i].frame & {FRAME_BITS{match_vec[i]}});
      end
   end

   // a cell shifts when no stop mark lies in front of it
   always_comb begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
         shift_vec[i] = ~|(stop_vec & ({TLB_DEPTH{1'b1}} >> (TLB_DEPTH - i)));
      end
   end

   // ---------------- entry limit ----------------
   assign ent_wide      = {{LIM_W{1'b0}}, entries_ff};
   assign ent_ext       = ent_wide[LIM_W-1:0];
   assign used_lim_wide = {{LIM_W{1'b0}}, used_ff};
   assign used_ext      = used_lim_wide[LIM_W-1:0];

   always_comb begin
      if (ent_ext == '0) begin
         limit = LIM_W'(1);
      end else if (ent_ext > LIM_W'(TLB_DEPTH)) begin
         limit = LIM_W'(TLB_DEPTH);
      end else begin
         limit = ent_ext;
      end
   end

   assign insert_ok = used_ext < limit;

   assign used_wide = {{REMOVED_W{1'b0}}, used_ff};
   assign cnt_wide  = {{REMOVED_W{1'b0}}, cnt_ff};

   // ---------------- control ----------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      sweep_in     = sweep_ff;
      rmv_in       = rmv_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_op       = CELL_HOLD;
      stop_vec     = match_vec;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.req_type == REQ_INVAL) begin
               cmd_op   = CELL_DROP;
               rmv_in   = proc_vec;
               cnt_in   = '0;
               sweep_in = SWP_W'(TLB_DEPTH - 1);
               state_in = ST_SWEEP;
            end else if (out_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               case (req_ff.req_type)
                  REQ_LOOKUP: begin
                     if (enabled_ff && any_match) begin
                        cmd_op           = CELL_SHIFT;
                        rsp_in.hit       = 1'b1;
                        rsp_in.frame_out = hit_frame;
                     end
                  end
                  REQ_FILL: begin
                     if (enabled_ff) begin
                        cmd_op = CELL_SHIFT;
                        if (any_match) begin
                           rsp_in.hit       = 1'b1;
                           rsp_in.frame_out = hit_frame;
                        end else if (insert_ok) begin
                           stop_vec = ~valid_vec;
                           used_in  = used_ff + CNT_W'(1);
                        end else begin
                           // full: the tail entry drops off the chain
                           stop_vec       = last_vec;
                           rsp_in.evicted = 1'b1;
                        end
                     end
                  end
                  REQ_FLUSH: begin
                     if (enabled_ff) begin
                        cmd_op               = CELL_CLEAR;
                        rsp_in.removed_count = used_wide[REMOVED_W-1:0];
                        used_in              = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            cmd_op   = CELL_COMPACT;
            rmv_in   = rmv_ff >> 1;
            cnt_in   = cnt_ff + {{(CNT_W-1){1'b0}}, rmv_ff[0]};
            sweep_in = sweep_ff - SWP_W'(1);
            if (sweep_ff == '0) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_in               = '0;
               rsp_in.removed_count = cnt_wide[REMOVED_W-1:0];
               rsp_valid_in         = 1'b1;
               used_in              = used_ff - cnt_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      entries_in = entries_ff;
      enabled_in = enabled_ff;
      if (cfg_write) begin
         case (paddr[2])
            CSR_ENTRIES: entries_in = pwdata[ENTRIES_W-1:0];
            CSR_ENABLED: enabled_in = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_ENTRIES: prdata = {{(32-ENTRIES_W){1'b0}}, entries_ff};
         CSR_ENABLED: prdata = {31'd0, enabled_ff};
         default:     prdata = '0;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         entries_ff   <= ENTRIES_RESET;
         enabled_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         entries_ff   <= entries_in;
         enabled_ff   <= enabled_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      cnt_ff   <= cnt_in;
      sweep_ff <= sweep_in;
      rmv_ff   <= rmv_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/tlbl_checker.sv */
// tlbl_checker: port-level assertions for tlb_lru_process_tagged, bound to the top level
// depends on tlbl_pkg and tlb_lru_process_tagged
module tlbl_checker
   import tlbl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input tlbl_rsp_type rsp_data
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // one request at a time: an accepted beat closes the input side for the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // a miss carries no frame
   a_miss_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.frame_out == '0)
      else $error("miss reported a frame");

   // a fill either hits or evicts, never both, and neither goes with a removal count
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.hit || rsp_data.evicted) |->
         !(rsp_data.hit && rsp_data.evicted) && rsp_data.removed_count == '0)
      else $error("inconsistent result fields");

endmodule

bind tlb_lru_process_tagged tlbl_checker u_tlbl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
